/* rtl/fscc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fscc_pkg
// Shared widths, constants and types for the speed and curl colour map core.
// ----------------------------------------------------------------------------
package fscc_pkg;

   localparam int VEL_W       = 16;
   localparam int GAIN_W      = 16;
   localparam int CHAN_W      = 8;
   localparam int CSR_IDX_W   = 1;

   // squares, sum of squares and the square-root radicand (s2 * 2^16)
   localparam int SQ_W        = 2 * VEL_W - 1;
   localparam int S2_W        = SQ_W + 1;
   localparam int RAD_W       = S2_W + 16;
   localparam int ROOT_W      = RAD_W / 2;
   localparam int REM_W       = ROOT_W + 2;
   localparam int SQRT_STEPS_DEFAULT = 4;

   // curl: difference of differences and its magnitude
   localparam int CURL_W      = VEL_W + 2;
   localparam int MAG_W       = CURL_W - 1;
   localparam int CURL_P_W    = MAG_W + GAIN_W;
   localparam int CURL_Q_W    = 25;
   localparam int SPEED_P_W   = ROOT_W + GAIN_W;
   localparam int SPEED_Q_W   = 32;

   localparam logic [CURL_Q_W-1:0]  CURL_ONE  = CURL_Q_W'(1) << 24;
   localparam logic [SPEED_Q_W-1:0] SPEED_ONE = SPEED_Q_W'(1) << 31;

   localparam logic [GAIN_W-1:0] SPEED_GAIN_RESET = 16'd4267;
   localparam logic [GAIN_W-1:0] CURL_GAIN_RESET  = 16'd51200;

   localparam logic [CHAN_W-1:0] CHAN_FULL = 8'd255;

   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_GAIN = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CURL_GAIN  = 1'b1;

   typedef struct packed {
      logic                wall;
      logic                curl_neg;
      logic [CURL_Q_W-1:0] curl_q;
   } fscc_side_type;

endpackage

/* rtl/flow_speed_curl_colormap_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flow_speed_curl_colormap_core
// Colours one flow cell per clock: a speed pixel and a curl pixel.
// ----------------------------------------------------------------------------
// Fully pipelined: one cell is taken every clock and its pixels appear after
// stage 1, stage 2, the square-root pipeline, which resolves SQRT_STEPS
// result bits per stage, stage 3 and the output register. The whole pipe
// moves together and halts only while a finished pixel pair waits on
// rsp_ready. Gains may be written only while the pipe is empty.
module flow_speed_curl_colormap_core #(
   parameter int SQRT_STEPS = fscc_pkg::SQRT_STEPS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [fscc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fscc_pkg::GAIN_W-1:0]    csr_wdata,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [fscc_pkg::VEL_W-1:0] req_vel_x,
   input  logic signed [fscc_pkg::VEL_W-1:0] req_vel_y,
   input  logic signed [fscc_pkg::VEL_W-1:0] req_vel_x_above,
   input  logic signed [fscc_pkg::VEL_W-1:0] req_vel_x_below,
   input  logic signed [fscc_pkg::VEL_W-1:0] req_vel_y_left,
   input  logic signed [fscc_pkg::VEL_W-1:0] req_vel_y_right,
   input  logic                           req_is_wall,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [fscc_pkg::CHAN_W-1:0]    rsp_speed_red,
   output logic [fscc_pkg::CHAN_W-1:0]    rsp_speed_green,
   output logic [fscc_pkg::CHAN_W-1:0]    rsp_speed_blue,
   output logic [fscc_pkg::CHAN_W-1:0]    rsp_curl_red,
   output logic [fscc_pkg::CHAN_W-1:0]    rsp_curl_green,
   output logic [fscc_pkg::CHAN_W-1:0]    rsp_curl_blue
);
   import fscc_pkg::*;

   logic en;

   // gains
   logic [GAIN_W-1:0] speed_gain_ff;
   logic [GAIN_W-1:0] curl_gain_ff;

   // stage 1: squares, curl magnitude
   logic              s1_vld_ff;
   logic [SQ_W-1:0]   s1_sqx_ff;
   logic [SQ_W-1:0]   s1_sqy_ff;
   logic [MAG_W-1:0]  s1_mag_ff;
   logic              s1_neg_ff;
   logic              s1_wall_ff;
   logic signed [2*VEL_W-1:0] sqx_in;
   logic signed [2*VEL_W-1:0] sqy_in;
   logic signed [CURL_W-1:0]  curl_in;
   logic [MAG_W-1:0]  mag_in;

   // stage 2: sum of squares, curl product
   logic              s2_vld_ff;
   logic [S2_W-1:0]   s2_sum_ff;
   logic [CURL_P_W-1:0] s2_cp_ff;
   logic              s2_neg_ff;
   logic              s2_wall_ff;
   fscc_side_type     sq_side;

   // square root
   logic              rt_vld;
   logic [ROOT_W-1:0] rt_root;
   fscc_side_type     rt_side;

   // stage 3: speed product, curl pixel
   logic              s3_vld_ff;
   logic [SPEED_P_W-1:0] s3_sp_ff;
   logic              s3_wall_ff;
   logic [CHAN_W-1:0] s3_cred_ff;
   logic [CHAN_W-1:0] s3_cblue_ff;
   logic [CURL_Q_W-1:0]   cdiff;
   logic [CURL_Q_W+7:0]   cscale;
   logic [CHAN_W-1:0]     cval;

   // output register
   logic              rsp_valid_ff;
   logic [CHAN_W-1:0] sred_ff, sgreen_ff, sblue_ff, cred_ff, cgreen_ff, cblue_ff;
   logic [SPEED_Q_W-1:0]  psat;
   logic [SPEED_Q_W-1:0]  pdiff;
   logic [SPEED_Q_W+7:0]  rscale;
   logic [SPEED_Q_W+7:0]  bscale;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_gain_ff <= SPEED_GAIN_RESET;
         curl_gain_ff  <= CURL_GAIN_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SPEED_GAIN: speed_gain_ff <= csr_wdata;
            CSR_CURL_GAIN:  curl_gain_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---- stage 1
   always_comb begin
      sqx_in  = req_vel_x * req_vel_x;
      sqy_in  = req_vel_y * req_vel_y;
      curl_in = (CURL_W'(req_vel_x_below) - CURL_W'(req_vel_x_above))
              - (CURL_W'(req_vel_y_right) - CURL_W'(req_vel_y_left));
      mag_in  = curl_in[CURL_W-1] ? MAG_W'(-curl_in) : curl_in[MAG_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_valid;
      end
      if (en) begin
         s1_sqx_ff  <= sqx_in[SQ_W-1:0];
         s1_sqy_ff  <= sqy_in[SQ_W-1:0];
         s1_mag_ff  <= mag_in;
         s1_neg_ff  <= curl_in[CURL_W-1];
         s1_wall_ff <= req_is_wall;
      end
   end

   // ---- stage 2
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (en) begin
         s2_vld_ff <= s1_vld_ff;
      end
      if (en) begin
         s2_sum_ff  <= S2_W'(s1_sqx_ff) + S2_W'(s1_sqy_ff);
         s2_cp_ff   <= CURL_P_W'(s1_mag_ff) * CURL_P_W'(curl_gain_ff);
         s2_neg_ff  <= s1_neg_ff;
         s2_wall_ff <= s1_wall_ff;
      end
   end

   always_comb begin
      sq_side.wall     = s2_wall_ff;
      sq_side.curl_neg = s2_neg_ff;
      sq_side.curl_q   = (s2_cp_ff > CURL_P_W'(CURL_ONE)) ? CURL_ONE
                                                         : s2_cp_ff[CURL_Q_W-1:0];
   end

   fscc_isqrt_pipe #(
      .STEPS_PER_STAGE (SQRT_STEPS)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s2_vld_ff),
      .in_rad    ({s2_sum_ff, 16'd0}),
      .in_side   (sq_side),
      .out_valid (rt_vld),
      .out_root  (rt_root),
      .out_side  (rt_side)
   );

   // ---- stage 3
   always_comb begin
      cdiff  = CURL_ONE - rt_side.curl_q;
      cscale = {cdiff, 8'd0} - (CURL_Q_W+8)'(cdiff);
      cval   = CHAN_FULL - cscale[CURL_Q_W+6 -: CHAN_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (en) begin
         s3_vld_ff <= rt_vld;
      end
      if (en) begin
         s3_sp_ff    <= SPEED_P_W'(rt_root) * SPEED_P_W'(speed_gain_ff);
         s3_wall_ff  <= rt_side.wall;
         s3_cred_ff  <= rt_side.curl_neg ? cval : '0;
         s3_cblue_ff <= rt_side.curl_neg ? '0 : cval;
      end
   end

   // ---- output stage
   always_comb begin
      psat   = (s3_sp_ff > SPEED_P_W'(SPEED_ONE)) ? SPEED_ONE
                                                  : s3_sp_ff[SPEED_Q_W-1:0];
      pdiff  = SPEED_ONE - psat;
      rscale = {psat, 8'd0} - (SPEED_Q_W+8)'(psat);
      bscale = {pdiff, 8'd0} - (SPEED_Q_W+8)'(pdiff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= s3_vld_ff;
      end
      if (en) begin
         if (s3_wall_ff) begin
            sred_ff   <= '0;
            sgreen_ff <= CHAN_FULL;
            sblue_ff  <= '0;
            cred_ff   <= '0;
            cgreen_ff <= CHAN_FULL;
            cblue_ff  <= '0;
         end else begin
            sred_ff   <= rscale[SPEED_Q_W+6 -: CHAN_W];
            sgreen_ff <= '0;
            sblue_ff  <= bscale[SPEED_Q_W+6 -: CHAN_W];
            cred_ff   <= s3_cred_ff;
            cgreen_ff <= '0;
            cblue_ff  <= s3_cblue_ff;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_speed_red   = sred_ff;
   assign rsp_speed_green = sgreen_ff;
   assign rsp_speed_blue  = sblue_ff;
   assign rsp_curl_red    = cred_ff;
   assign rsp_curl_green  = cgreen_ff;
   assign rsp_curl_blue   = cblue_ff;

   // ---- checks
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid_ff)
      else $error("pipe halted with empty output register");

   a_wall_pixels: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && sgreen_ff != 8'd0) |->
         (sred_ff == 8'd0 && sblue_ff == 8'd0 && cgreen_ff == CHAN_FULL
          && cred_ff == 8'd0 && cblue_ff == 8'd0))
      else $error("wall pixel not pure green");

   a_speed_ramp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && sgreen_ff == 8'd0) |->
         ((9'(sred_ff) + 9'(sblue_ff)) == 9'd255
          || (9'(sred_ff) + 9'(sblue_ff)) == 9'd254))
      else $error("speed red and blue do not sum to full scale");

   a_curl_one_sided: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && cgreen_ff == 8'd0) |-> (cred_ff == 8'd0 || cblue_ff == 8'd0))
      else $error("curl pixel has both red and blue");

endmodule

/* rtl/fscc_isqrt_pipe.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fscc_isqrt_pipe
// Pipelined integer square root, a fixed number of digit steps per stage,
// with side data and valid bits carried alongside.
// ----------------------------------------------------------------------------
module fscc_isqrt_pipe #(
   parameter int STEPS_PER_STAGE = fscc_pkg::SQRT_STEPS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [fscc_pkg::RAD_W-1:0]  in_rad,
   input  fscc_pkg::fscc_side_type     in_side,
   output logic                        out_valid,
   output logic [fscc_pkg::ROOT_W-1:0] out_root,
   output fscc_pkg::fscc_side_type     out_side
);
   import fscc_pkg::*;

   localparam int STAGES = ROOT_W / STEPS_PER_STAGE;

   logic          vld_ff  [STAGES];
   logic [REM_W-1:0]  rem_ff  [STAGES];
   logic [ROOT_W-1:0] root_ff [STAGES];
   logic [RAD_W-1:0]  rad_ff  [STAGES];
   fscc_side_type     side_ff [STAGES];

   logic              vld_x  [STAGES+1];
   logic [REM_W-1:0]  rem_x  [STAGES+1];
   logic [ROOT_W-1:0] root_x [STAGES+1];
   logic [RAD_W-1:0]  rad_x  [STAGES+1];
   fscc_side_type     side_x [STAGES+1];

   logic [REM_W-1:0]  rem_in  [STAGES];
   logic [ROOT_W-1:0] root_in [STAGES];
   logic [RAD_W-1:0]  rad_in  [STAGES];

   assign vld_x[0]  = in_valid;
   assign rem_x[0]  = '0;
   assign root_x[0] = '0;
   assign rad_x[0]  = in_rad;
   assign side_x[0] = in_side;

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      assign vld_x[k+1]  = vld_ff[k];
      assign rem_x[k+1]  = rem_ff[k];
      assign root_x[k+1] = root_ff[k];
      assign rad_x[k+1]  = rad_ff[k];
      assign side_x[k+1] = side_ff[k];

      always_comb begin : p_step
         logic [REM_W-1:0]  r;
         logic [REM_W-1:0]  sh;
         logic [REM_W-1:0]  trial;
         logic [ROOT_W-1:0] q;
         logic [RAD_W-1:0]  a;
         r = rem_x[k];
         q = root_x[k];
         a = rad_x[k];
         for (int j = 0; j < STEPS_PER_STAGE; j++) begin
            sh    = {r[REM_W-3:0], a[RAD_W-1 -: 2]};
            trial = {q, 2'b01};
            if (sh >= trial) begin
               r = sh - trial;
               q = {q[ROOT_W-2:0], 1'b1};
            end else begin
               r = sh;
               q = {q[ROOT_W-2:0], 1'b0};
            end
            a = a << 2;
         end
         rem_in[k]  = r;
         root_in[k] = q;
         rad_in[k]  = a;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_x[k];
         end
         if (en) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            rad_ff[k]  <= rad_in[k];
            side_ff[k] <= side_x[k];
         end
      end
   end

   assign out_valid = vld_x[STAGES];
   assign out_root  = root_x[STAGES];
   assign out_side  = side_x[STAGES];

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the speed and curl colour map core.
// ----------------------------------------------------------------------------
// A queue of flow cells feeds a valid/ready driver. The monitor predicts each
// accepted cell's two pixels using a local copy of the gains, then checks every
// returned pixel pair field by field against the oldest prediction. The gains
// are rewritten between phases, and only once the pipe has drained. Both
// sides idle at random, and the receiver now and then holds off long enough
// to back the pipe up into the request side.
// ----------------------------------------------------------------------------
module tb;
   import fscc_pkg::*;

   typedef struct packed {
      logic signed [VEL_W-1:0] vel_x, vel_y, vel_x_above, vel_x_below,
                               vel_y_left, vel_y_right;
      logic                    is_wall;
   } cell_type;

   typedef struct packed {
      logic [CHAN_W-1:0] speed_red, speed_green, speed_blue;
      logic [CHAN_W-1:0] curl_red, curl_green, curl_blue;
   } pixel_pair_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_SPEED_GAIN;
   logic [GAIN_W-1:0]    csr_wdata = '0;

   logic     req_valid = 1'b0;
   logic     req_ready;
   cell_type cell_drv  = '0;

   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [CHAN_W-1:0] rsp_speed_red, rsp_speed_green, rsp_speed_blue;
   logic [CHAN_W-1:0] rsp_curl_red, rsp_curl_green, rsp_curl_blue;

   cell_type       cells_to_send[$];
   pixel_pair_type pixels_due[$];
   pixel_pair_type want_px;

   logic [GAIN_W-1:0] speed_gain_m, curl_gain_m;
   int   cells_queued = 0;
   int   pixels_seen  = 0;
   int   mismatches   = 0;
   logic req_taken    = 1'b0;
   logic rsp_taken    = 1'b0;
   logic rsp_choked   = 1'b0;
   int   send_gap     = 0;
   int   send_mode    = 1;
   int   recv_mode    = 1;
   int   recv_stall   = 0;
   int   hold_left    = 0;
   int   choke_at     = 0;

   flow_speed_curl_colormap_core dut (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_vel_x       (cell_drv.vel_x),
      .req_vel_y       (cell_drv.vel_y),
      .req_vel_x_above (cell_drv.vel_x_above),
      .req_vel_x_below (cell_drv.vel_x_below),
      .req_vel_y_left  (cell_drv.vel_y_left),
      .req_vel_y_right (cell_drv.vel_y_right),
      .req_is_wall     (cell_drv.is_wall),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_speed_red   (rsp_speed_red),
      .rsp_speed_green (rsp_speed_green),
      .rsp_speed_blue  (rsp_speed_blue),
      .rsp_curl_red    (rsp_curl_red),
      .rsp_curl_green  (rsp_curl_green),
      .rsp_curl_blue   (rsp_curl_blue)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #1_000_000;
      $display("tb: failure");
      $finish;
   end

   // ------------------------------------------------------------------ model

   function automatic longint root_floor(input longint n);
      longint r, t;
      r = 0;
      for (int b = 24; b >= 0; b--) begin
         t = r | (longint'(1) << b);
         if (t * t <= n) r = t;
      end
      return r;
   endfunction

   function automatic pixel_pair_type colour_cell(input cell_type c,
                                                  input logic [GAIN_W-1:0] sg,
                                                  input logic [GAIN_W-1:0] cg);
      pixel_pair_type px;
      longint vx, vy, xa, xb, yl, yr;
      longint speed, p, curl, mag, q, lit;
      longint speed_full, curl_full;
      px = '0;
      speed_full = longint'(SPEED_ONE);
      curl_full  = longint'(CURL_ONE);
      if (c.is_wall) begin
         px.speed_green = 8'd255;
         px.curl_green  = 8'd255;
         return px;
      end
      vx = c.vel_x;
      vy = c.vel_y;
      xa = c.vel_x_above;
      xb = c.vel_x_below;
      yl = c.vel_y_left;
      yr = c.vel_y_right;

      speed = root_floor((vx * vx + vy * vy) << 16);
      p = speed * longint'(sg);
      if (p > speed_full) p = speed_full;
      px.speed_red  = 8'((255 * p) >> 31);
      px.speed_blue = 8'((255 * (speed_full - p)) >> 31);

      // unhalved neighbour differences, Q.0 like the velocities
      curl = (xb - xa) - (yr - yl);
      mag  = (curl < 0) ? -curl : curl;
      q    = mag * longint'(cg);
      if (q > curl_full) q = curl_full;
      lit = 255 - ((255 * (curl_full - q)) >> 24);
      if (curl < 0) px.curl_red = 8'(lit);
      else px.curl_blue = 8'(lit);
      return px;
   endfunction

   // -------------------------------------------------------------- stimulus

   function automatic logic signed [VEL_W-1:0] sat_vel(input int v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return 16'(v);
   endfunction

   function automatic int rand_span(input int s);
      return int'($urandom_range(0, 2 * s)) - s;
   endfunction

   function automatic int pick_extreme();
      case ($urandom_range(0, 5))
         0: return -32768;
         1: return 32767;
         2: return 0;
         3: return -1;
         4: return 1;
         default: return rand_span(32767);
      endcase
   endfunction

   function automatic cell_type make_cell(input int vx, input int vy, input int xa,
                                          input int xb, input int yl, input int yr,
                                          input bit wall);
      cell_type c;
      c.vel_x       = sat_vel(vx);
      c.vel_y       = sat_vel(vy);
      c.vel_x_above = sat_vel(xa);
      c.vel_x_below = sat_vel(xb);
      c.vel_y_left  = sat_vel(yl);
      c.vel_y_right = sat_vel(yr);
      c.is_wall     = wall;
      return c;
   endfunction

   function automatic cell_type random_cell();
      int  kind, vx, vy, spread;
      bit  wall;
      kind = $urandom_range(0, 99);
      wall = ($urandom_range(0, 9) == 0);
      if (kind < 45) begin
         // smooth flow: neighbours close to the cell itself
         vx = rand_span(3000);
         vy = rand_span(3000);
         spread = ($urandom_range(0, 3) == 0) ? 2000 : 300;
         return make_cell(vx, vy, vx + rand_span(spread), vx + rand_span(spread),
                          vy + rand_span(spread), vy + rand_span(spread), wall);
      end else if (kind < 75) begin
         return make_cell(int'($signed(16'($urandom))), int'($signed(16'($urandom))),
                          int'($signed(16'($urandom))), int'($signed(16'($urandom))),
                          int'($signed(16'($urandom))), int'($signed(16'($urandom))), wall);
      end else if (kind < 90) begin
         return make_cell(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                          pick_extreme(), pick_extreme(), wall);
      end
      return make_cell(rand_span(16384), rand_span(16384), rand_span(16384),
                       rand_span(16384), rand_span(16384), rand_span(16384), wall);
   endfunction

   function automatic int idle_draw(input int mode);
      case (mode)
         0: return 0;
         1: return $urandom_range(0, 18);
         default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
      endcase
   endfunction

   task automatic queue_cell(input cell_type c);
      cells_to_send.push_back(c);
      cells_queued++;
   endtask

   task automatic write_gain(input logic [CSR_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic run_phase(input bit set_gains, input logic [GAIN_W-1:0] sg,
                            input logic [GAIN_W-1:0] cg, input int n_random);
      if (set_gains) begin
         write_gain(CSR_SPEED_GAIN, sg);
         write_gain(CSR_CURL_GAIN, cg);
      end
      @(posedge clock);
      repeat (n_random) queue_cell(random_cell());
      while (pixels_seen < cells_queued) @(negedge clock);
      // pipe is 10 deep at the default square-root split
      repeat (16) @(negedge clock);
   endtask

   // ---------------------------------------------------------- request side

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else if (!req_valid || req_taken) begin
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap  <= send_gap - 1;
         end else if (cells_to_send.size() != 0) begin
            cell_drv  <= cells_to_send.pop_front();
            req_valid <= 1'b1;
            if ($urandom_range(0, 39) == 0) send_mode = $urandom_range(0, 2);
            send_gap  <= rsp_choked ? 0 : idle_draw(send_mode);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // --------------------------------------------------------- response side

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         hold_left  <= 0;
         rsp_choked <= 1'b0;
         choke_at   <= $urandom_range(10, 30);
      end else if (rsp_taken && pixels_seen == choke_at) begin
         // long hold-off so the pipe fills and back-pressures requests
         rsp_ready  <= 1'b0;
         hold_left  <= 239;
         rsp_choked <= 1'b1;
         choke_at   <= choke_at + $urandom_range(150, 250);
      end else if (rsp_taken) begin
         if ($urandom_range(0, 39) == 0) recv_mode = $urandom_range(0, 2);
         recv_stall = idle_draw(recv_mode);
         rsp_ready <= (recv_stall == 0);
         hold_left <= (recv_stall == 0) ? 0 : recv_stall - 1;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_ready  <= 1'b1;
         rsp_choked <= 1'b0;
      end
   end

   // --------------------------------------------------------------- monitor

   task automatic check_chan(input string chan, input logic [CHAN_W-1:0] want,
                             input logic [CHAN_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, chan, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         speed_gain_m = SPEED_GAIN_RESET;
         curl_gain_m  = CURL_GAIN_RESET;
         req_taken   <= 1'b0;
         rsp_taken   <= 1'b0;
         pixels_seen <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SPEED_GAIN: speed_gain_m = csr_wdata;
               CSR_CURL_GAIN:  curl_gain_m  = csr_wdata;
            endcase
         end
         req_taken <= req_valid && req_ready;
         rsp_taken <= rsp_valid && rsp_ready;
         if (req_valid && req_ready)
            pixels_due.push_back(colour_cell(cell_drv, speed_gain_m, curl_gain_m));
         if (rsp_valid && rsp_ready) begin
            pixels_seen <= pixels_seen + 1;
            if (pixels_due.size() == 0) begin
               $display("%0t: pixel pair expected none, got %h", $time,
                        {rsp_speed_red, rsp_speed_green, rsp_speed_blue,
                         rsp_curl_red, rsp_curl_green, rsp_curl_blue});
               mismatches++;
            end else begin
               want_px = pixels_due.pop_front();
               check_chan("speed_red",   want_px.speed_red,   rsp_speed_red);
               check_chan("speed_green", want_px.speed_green, rsp_speed_green);
               check_chan("speed_blue",  want_px.speed_blue,  rsp_speed_blue);
               check_chan("curl_red",    want_px.curl_red,    rsp_curl_red);
               check_chan("curl_green",  want_px.curl_green,  rsp_curl_green);
               check_chan("curl_blue",   want_px.curl_blue,   rsp_curl_blue);
            end
         end
      end
   end

   // ------------------------------------------------------------- sequence

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed cells at reset gains
      queue_cell(make_cell(0, 0, 0, 0, 0, 0, 1'b0));
      queue_cell(make_cell(0, 0, 0, 0, 0, 0, 1'b1));
      queue_cell(make_cell(-32768, -32768, 32767, -32768, -32768, 32767, 1'b1));
      queue_cell(make_cell(32767, 32767, 32767, -32768, -32768, 32767, 1'b1));
      queue_cell(make_cell(32767, 32767, -32768, 32767, 32767, -32768, 1'b0));
      queue_cell(make_cell(-32768, -32768, 32767, -32768, -32768, 32767, 1'b0));
      queue_cell(make_cell(32767, 0, 0, 0, 0, 0, 1'b0));
      queue_cell(make_cell(0, -32768, 0, 0, 0, 0, 1'b0));
      queue_cell(make_cell(1, 0, 0, 0, 0, 0, 1'b0));
      queue_cell(make_cell(0, 0, 0, 1, 0, 0, 1'b0));
      queue_cell(make_cell(0, 0, 1, 0, 0, 0, 1'b0));
      queue_cell(make_cell(0, 0, 0, 0, 0, 1, 1'b0));
      queue_cell(make_cell(0, 0, 0, 0, 1, 0, 1'b0));
      queue_cell(make_cell(1966, 0, 0, 0, 0, 0, 1'b0));
      queue_cell(make_cell(1200, -1500, 0, 327, 0, 0, 1'b0));
      queue_cell(make_cell(0, 0, -100, 228, 0, 0, 1'b0));
      queue_cell(make_cell(21845, -21846, 21845, -21846, 21845, -21846, 1'b0));
      queue_cell(make_cell(-21846, 21845, -21846, 21845, -21846, 21845, 1'b0));
      queue_cell(make_cell(-1, -1, -1, -1, -1, -1, 1'b0));

      run_phase(1'b0, SPEED_GAIN_RESET, CURL_GAIN_RESET, 70);
      run_phase(1'b1, 16'd0, 16'd0, 50);
      run_phase(1'b1, 16'hFFFF, 16'hFFFF, 60);
      run_phase(1'b1, 16'($urandom), 16'($urandom), 70);
      run_phase(1'b1, 16'd1, 16'd1, 40);
      run_phase(1'b1, 16'($urandom_range(0, 8192)), 16'($urandom), 60);
      run_phase(1'b1, SPEED_GAIN_RESET, CURL_GAIN_RESET, 50);

      if (mismatches == 0 && pixels_due.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

/* sim.f */
rtl/fscc_pkg.sv
rtl/fscc_isqrt_pipe.sv
rtl/flow_speed_curl_colormap_core.sv
tb/tb.sv
